// File: rtl/core/binary_erode_dilate_square_core_macros.svh
// assertion macros shared by the checker of the erode / dilate core
// no dependencies; clocked on clk_i and disabled while rst_ni is low
`ifndef BINARY_ERODE_DILATE_SQUARE_CORE_MACROS_SVH
`define BINARY_ERODE_DILATE_SQUARE_CORE_MACROS_SVH

// same-cycle implication
`define BEDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BEDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/beds_pkg.sv
// shared constants and types of the binary erode / dilate core
// no dependencies
package beds_pkg;

  localparam int DEF_MAX_RADIUS = 7;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } mode_e;

  // register values after reset
  localparam int RST_RADIUS = 1;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

endpackage

// File: rtl/core/binary_erode_dilate_square_core.sv
// binary erosion / dilation with a square window, streamed in raster order
// depends on beds_pkg and beds_linebuf
//
// Input channel: one binary pixel per request (in_valid_i / in_stall_o), raster
// order; the block tracks row and column itself. Output channel: result pixels
// (out_valid_o / out_stall_i) carrying row, column, value and a flag on the last
// result that an input pixel causes. An input pixel gives zero, one or two results:
// the interior centre whose square window it completes, and itself if it lies in
// the border margin, in that order.
// Path: a pixel is held in the second stage, then its results in the output buffer.
// Throughput: one pixel per clock, set by the single read and single write port
// of the column history memory; only the output channel holds pixels: out_stall_i
// can stall any pixel, and at one result per clock it slows those with two results.
// Configuration (mode, radius, width, height) must be written through the plain
// write port while the block is idle, unchecked by it; values are clamped on write.
// Reset: position counters go to row 0, column 0 and registers to erode, radius
// 1, 640 x 480. The history memory is not cleared (no clearing pass): a frame's
// first rows give no interior result and fill each column's history before use.
// Stall: a two-entry output buffer holds results; while it has no room for the
// results of the pixel in flight, in_stall_o is raised and nothing is lost.
module binary_erode_dilate_square_core #(
  parameter int MAX_RADIUS = beds_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = beds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = beds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [beds_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [beds_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                pixel_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [$clog2(MAX_HEIGHT)-1:0]       out_row_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        out_col_o,
  output logic                                pixel_out_o,
  output logic                                last_of_step_o
);

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = $clog2(MAX_HEIGHT);
  localparam int WCntW = $clog2(MAX_WIDTH + 1);
  localparam int HCntW = $clog2(MAX_HEIGHT + 1);
  localparam int RadW  = $clog2(MAX_RADIUS + 1);
  localparam int HistW = 2 * MAX_RADIUS;
  localparam int WinN  = 2 * MAX_RADIUS + 1;

  localparam int RstRad = (beds_pkg::RST_RADIUS > MAX_RADIUS) ? MAX_RADIUS
                                                              : beds_pkg::RST_RADIUS;
  localparam int RstW   = (beds_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                            : beds_pkg::RST_WIDTH;
  localparam int RstH   = (beds_pkg::RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : beds_pkg::RST_HEIGHT;

  // configuration registers, held as effective (clamped) values
  beds_pkg::mode_e   mode_q;
  logic [RadW-1:0]   rad_q;
  logic [WCntW-1:0]  w_q;
  logic [HCntW-1:0]  h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= beds_pkg::MODE_ERODE;
      rad_q  <= RadW'(RstRad);
      w_q    <= WCntW'(RstW);
      h_q    <= HCntW'(RstH);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        beds_pkg::CFG_MODE: begin
          mode_q <= beds_pkg::mode_e'(cfg_data_i[0]);
        end
        beds_pkg::CFG_RADIUS: begin
          if (32'(cfg_data_i[2:0]) > MAX_RADIUS) rad_q <= RadW'(MAX_RADIUS);
          else rad_q <= RadW'(cfg_data_i[2:0]);
        end
        beds_pkg::CFG_WIDTH: begin
          if (cfg_data_i[11:0] == 12'd0) w_q <= WCntW'(1);
          else if (32'(cfg_data_i[11:0]) > MAX_WIDTH) w_q <= WCntW'(MAX_WIDTH);
          else w_q <= WCntW'(cfg_data_i[11:0]);
        end
        beds_pkg::CFG_HEIGHT: begin
          if (cfg_data_i == '0) h_q <= HCntW'(1);
          else if (32'(cfg_data_i) > MAX_HEIGHT) h_q <= HCntW'(MAX_HEIGHT);
          else h_q <= HCntW'(cfg_data_i);
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // position of the incoming pixel
  logic [ColW-1:0] col_q, col_d, c0;
  logic [RowW-1:0] row_q, row_d, r0;
  logic [RowW:0]   rr, rn;
  logic [ColW:0]   cn;
  logic            in_acc, commit;

  always_comb begin
    // a stale position after a geometry change wraps first
    if (32'(col_q) >= 32'(w_q)) begin
      c0 = '0;
      rr = (RowW+1)'(row_q) + 1'b1;
    end else begin
      c0 = col_q;
      rr = (RowW+1)'(row_q);
    end
    r0 = (32'(rr) >= 32'(h_q)) ? '0 : rr[RowW-1:0];

    cn    = (ColW+1)'(c0) + 1'b1;
    rn    = (RowW+1)'(r0) + 1'b1;
    col_d = cn[ColW-1:0];
    row_d = r0;
    if (32'(cn) >= 32'(w_q)) begin
      col_d = '0;
      row_d = (32'(rn) >= 32'(h_q)) ? '0 : rn[RowW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // second stage: history word arrives, window is updated, results formed
  logic            s1_valid_q;
  logic            s1_px_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (commit) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q  <= pixel_in_i;
      s1_col_q <= c0;
      s1_row_q <= r0;
    end
  end

  logic [HistW-1:0] hist_rd;
  logic [WinN-1:0]  vec;

  assign vec = {hist_rd, s1_px_q};

  beds_linebuf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (ColW),
    .DATA_W (HistW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (c0),
    .wr_en_i   (commit),
    .wr_addr_i (s1_col_q),
    .wr_data_i (vec[HistW-1:0]),
    .rd_data_o (hist_rd)
  );

  // last column vectors, entry k of win_n arrived k pixels ago
  logic [WinN-1:0] win_q [WinN];
  logic [WinN-1:0] win_n [WinN];
  logic [WinN-1:0] colmask, col_all, col_any;
  logic            hit_all, hit_any, win_px;

  always_comb begin
    win_n[0] = vec;
    for (int k = 1; k < WinN; k++) begin
      win_n[k] = win_q[k-1];
    end
    for (int k = 0; k < WinN; k++) begin
      colmask[k] = (k <= 2 * int'(rad_q));
    end
    for (int k = 0; k < WinN; k++) begin
      col_all[k] = ((win_n[k] & colmask) == colmask);
      col_any[k] = |(win_n[k] & colmask);
    end
    hit_all = &(col_all | ~colmask);
    hit_any = |(col_any & colmask);
    win_px  = (mode_q == beds_pkg::MODE_DILATE) ? hit_any : hit_all;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinN; k++) begin
        win_q[k] <= '0;
      end
    end else if (commit) begin
      for (int k = 0; k < WinN; k++) begin
        win_q[k] <= win_n[k];
      end
    end
  end

  logic            is_inner, is_border;
  logic [RowW-1:0] inner_row;
  logic [ColW-1:0] inner_col;
  logic [1:0]      n_res;

  always_comb begin
    is_inner  = (32'(s1_row_q) >= 2 * 32'(rad_q)) && (32'(s1_col_q) >= 2 * 32'(rad_q));
    is_border = (32'(s1_row_q) < 32'(rad_q)) ||
                (32'(s1_row_q) + 32'(rad_q) >= 32'(h_q)) ||
                (32'(s1_col_q) < 32'(rad_q)) ||
                (32'(s1_col_q) + 32'(rad_q) >= 32'(w_q));
    inner_row = RowW'(32'(s1_row_q) - 32'(rad_q));
    inner_col = ColW'(32'(s1_col_q) - 32'(rad_q));
    n_res     = 2'(is_inner) + 2'(is_border);
  end

  // ---------------------------------------------------------------------------
  // two-entry output buffer, slot 0 is on the ports
  logic [1:0]      cnt_q, cnt_d, base;
  logic [RowW-1:0] o_row_q [2];
  logic [RowW-1:0] o_row_d [2];
  logic [ColW-1:0] o_col_q [2];
  logic [ColW-1:0] o_col_d [2];
  logic [1:0]      o_px_q, o_px_d, o_last_q, o_last_d;
  logic            pop;
  logic [RowW-1:0] r0_row;
  logic [ColW-1:0] r0_col;
  logic            r0_px, r0_last;

  assign out_valid_o    = (cnt_q != 2'd0);
  assign pop            = out_valid_o && !out_stall_i;
  assign base           = cnt_q - 2'(pop);
  assign commit         = s1_valid_q && ((3'(base) + 3'(n_res)) <= 3'd2);
  assign in_stall_o     = s1_valid_q && !commit;
  assign in_acc         = in_valid_i && !in_stall_o;

  assign out_row_o      = o_row_q[0];
  assign out_col_o      = o_col_q[0];
  assign pixel_out_o    = o_px_q[0];
  assign last_of_step_o = o_last_q[0];

  always_comb begin
    // first result of the pixel: interior centre if any, else its border pass
    r0_row  = is_inner ? inner_row : s1_row_q;
    r0_col  = is_inner ? inner_col : s1_col_q;
    r0_px   = is_inner ? win_px : s1_px_q;
    r0_last = !(is_inner && is_border);

    o_row_d  = o_row_q;
    o_col_d  = o_col_q;
    o_px_d   = o_px_q;
    o_last_d = o_last_q;
    if (pop) begin
      o_row_d[0]  = o_row_q[1];
      o_col_d[0]  = o_col_q[1];
      o_px_d[0]   = o_px_q[1];
      o_last_d[0] = o_last_q[1];
    end
    if (commit && (n_res != 2'd0)) begin
      if (base == 2'd0) begin
        o_row_d[0]  = r0_row;
        o_col_d[0]  = r0_col;
        o_px_d[0]   = r0_px;
        o_last_d[0] = r0_last;
      end else begin
        o_row_d[1]  = r0_row;
        o_col_d[1]  = r0_col;
        o_px_d[1]   = r0_px;
        o_last_d[1] = r0_last;
      end
      // second result only when both apply, and then the buffer was drained
      if (n_res == 2'd2) begin
        o_row_d[1]  = s1_row_q;
        o_col_d[1]  = s1_col_q;
        o_px_d[1]   = s1_px_q;
        o_last_d[1] = 1'b1;
      end
    end
    cnt_d = base + (commit ? n_res : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_row_q  <= o_row_d;
    o_col_q  <= o_col_d;
    o_px_q   <= o_px_d;
    o_last_q <= o_last_d;
  end

endmodule

// File: rtl/core/beds_linebuf.sv
// line buffer: one column history word per image column
// single synchronous memory, registered read, bypass when the read hits the word written
module beds_linebuf #(
  parameter int DEPTH  = beds_pkg::DEF_MAX_WIDTH,
  parameter int ADDR_W = $clog2(beds_pkg::DEF_MAX_WIDTH),
  parameter int DATA_W = 2 * beds_pkg::DEF_MAX_RADIUS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // read and write of the same column in the same cycle: take the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_data_q;

endmodule

// File: rtl/core/beds_chk.sv
// port-level checker for the binary erode / dilate core, bound to the top level
// depends on binary_erode_dilate_square_core_macros.svh and beds_pkg
`include "binary_erode_dilate_square_core_macros.svh"

module beds_chk #(
  parameter int ROW_W = $clog2(beds_pkg::DEF_MAX_HEIGHT),
  parameter int COL_W = $clog2(beds_pkg::DEF_MAX_WIDTH)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ROW_W-1:0] out_row_o,
  input logic [COL_W-1:0] out_col_o,
  input logic             pixel_out_o,
  input logic             last_of_step_o
);

  // a stalled result stays on the ports unchanged
  `BEDS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_row_o) && $stable(out_col_o) && $stable(pixel_out_o) && $stable(last_of_step_o), "stalled result changed")

  // a result that is not the last of its pixel has its partner right behind it
  `BEDS_ASSERT_NEXT(a_pair_follows, out_valid_o && !out_stall_i && !last_of_step_o, out_valid_o, "second result of a pixel missing")

  // with the output buffer empty there is always room for a pixel's results
  `BEDS_ASSERT_NOW(a_no_idle_stall, !out_valid_o, !in_stall_o, "input stalled with empty output")

endmodule

bind binary_erode_dilate_square_core beds_chk #(
  .ROW_W ($clog2(MAX_HEIGHT)),
  .COL_W ($clog2(MAX_WIDTH))
) u_beds_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_row_o      (out_row_o),
  .out_col_o      (out_col_o),
  .pixel_out_o    (pixel_out_o),
  .last_of_step_o (last_of_step_o)
);

// File: tb/sv/tb_binary_erode_dilate_square_core.sv
`timescale 1ns / 100ps
// self-checking testbench of the binary erode / dilate core: directed table, then random frames
// depends on beds_pkg and binary_erode_dilate_square_core
module tb_binary_erode_dilate_square_core;

  localparam int MAX_R       = beds_pkg::DEF_MAX_RADIUS;
  localparam int MAX_W       = beds_pkg::DEF_MAX_WIDTH;
  localparam int MAX_H       = beds_pkg::DEF_MAX_HEIGHT;
  localparam int HIST_W      = 2 * MAX_R;
  localparam int WIN_N       = 2 * MAX_R + 1;
  localparam int LIMIT       = 1_000_000;
  localparam int SETTLE      = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_ITEMS     = 1100;

  typedef struct packed {
    logic [11:0] row;
    logic [10:0] col;
    logic        px;
    logic        last;
  } px_result_t;

  typedef struct {
    bit              is_cfg;
    beds_pkg::mode_e mode;
    logic [2:0]      radius;
    logic [11:0]     width;
    logic [12:0]     height;
    logic            px;
    bit              typed;
    logic [11:0]     row;
    logic [10:0]     col;
  } warmup_row_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [beds_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [beds_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic                            pixel_in  = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [11:0]                     out_row;
  logic [10:0]                     out_col;
  logic                            pixel_out;
  logic                            last_flag;

  // shadow of the register file
  beds_pkg::mode_e cfg_mode   = beds_pkg::MODE_ERODE;
  logic [2:0]      cfg_radius = 3'(beds_pkg::RST_RADIUS);
  logic [11:0]     cfg_width  = 12'(beds_pkg::RST_WIDTH);
  logic [12:0]     cfg_height = 13'(beds_pkg::RST_HEIGHT);

  // predicted state of the block
  logic [HIST_W-1:0] line_hist [MAX_W] = '{default: '0};
  logic [WIN_N-1:0]  win_cols  [WIN_N] = '{default: '0};
  int unsigned       col_fill  [MAX_W] = '{default: 0};
  int unsigned       pos_row = 0;
  int unsigned       pos_col = 0;

  px_result_t  pending [$];
  px_result_t  step_res [$];
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned sent_cnt  = 0;
  int unsigned hold_left = 0;
  bit          hold_req  = 1'b0;
  bit          quiet     = 1'b0;

  always #5 clk = ~clk;

  binary_erode_dilate_square_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pixel_in_i     (pixel_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .pixel_out_o    (pixel_out),
    .last_of_step_o (last_flag)
  );

  function automatic int unsigned eff_radius();
    return (cfg_radius > MAX_R) ? MAX_R : cfg_radius;
  endfunction

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    return (cfg_width > MAX_W) ? MAX_W : cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height == 0) return 1;
    return (cfg_height > MAX_H) ? MAX_H : cfg_height;
  endfunction

  // advances the shadow state by one pixel and leaves its results in step_res
  function automatic void morph_step(input logic px);
    int unsigned rr, ww, hh, r, c, k;
    logic [WIN_N-1:0] vec, mask, v;
    bit all_set, any_set;
    rr = eff_radius();
    ww = eff_width();
    hh = eff_height();
    step_res.delete();
    if (pos_col >= ww) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= hh) pos_row = 0;
    r = pos_row;
    c = pos_col;
    vec = {line_hist[c], px};
    line_hist[c] = vec[HIST_W-1:0];
    if (col_fill[c] < HIST_W) col_fill[c]++;
    for (k = WIN_N - 1; k > 0; k--) win_cols[k] = win_cols[k-1];
    win_cols[0] = vec;
    if (r >= 2 * rr && c >= 2 * rr) begin
      mask = WIN_N'((32'd1 << (2 * rr + 1)) - 1);
      all_set = 1'b1;
      any_set = 1'b0;
      for (k = 0; k <= 2 * rr; k++) begin
        v = win_cols[k] & mask;
        if (v != mask) all_set = 1'b0;
        if (v != '0) any_set = 1'b1;
      end
      step_res.push_back('{row: 12'(r - rr), col: 11'(c - rr),
                           px: (cfg_mode == beds_pkg::MODE_DILATE) ? any_set : all_set,
                           last: 1'b0});
    end
    if (r < rr || r + rr >= hh || c < rr || c + rr >= ww)
      step_res.push_back('{row: 12'(r), col: 11'(c), px: px, last: 1'b0});
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    pos_col++;
    if (pos_col >= ww) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= hh) pos_row = 0;
    end
  endfunction

  function automatic warmup_row_t cfg_row(input beds_pkg::mode_e m, input logic [2:0] rad,
                                          input logic [11:0] wd, input logic [12:0] ht);
    warmup_row_t t;
    t = '{is_cfg: 1'b1, mode: m, radius: rad, width: wd, height: ht,
          px: 1'b0, typed: 1'b0, row: '0, col: '0};
    return t;
  endfunction

  function automatic warmup_row_t pix_row(input logic px, input bit typed,
                                          input logic [11:0] row, input logic [10:0] col);
    warmup_row_t t;
    t = '{is_cfg: 1'b0, mode: beds_pkg::MODE_ERODE, radius: '0, width: '0, height: '0,
          px: px, typed: typed, row: row, col: col};
    return t;
  endfunction

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  // a typed request carries its own single expected result, the rest use the predictor
  task automatic send_pixel(input logic px, input bit typed,
                            input logic [11:0] want_row, input logic [10:0] want_col);
    morph_step(px);
    sent_cnt++;
    if (typed) pending.push_back('{row: want_row, col: want_col, px: px, last: 1'b1});
    else foreach (step_res[i]) pending.push_back(step_res[i]);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(99) < 20);
    end
    in_valid <= 1'b1;
    pixel_in <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle_pending();
    int unsigned waited;
    px_result_t lost;
    waited = 0;
    in_valid <= 1'b0;
    while (pending.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (pending.size() > 0) begin
      lost = pending.pop_front();
      report($sformatf("result row %0d col %0d never arrived", lost.row, lost.col));
    end
    // pixels with no result may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input beds_pkg::mode_e m, input logic [2:0] rad,
                            input logic [11:0] wd, input logic [12:0] ht);
    cfg_we   <= 1'b1;
    cfg_idx  <= beds_pkg::CFG_MODE;
    cfg_data <= beds_pkg::CFG_DATA_W'(m);
    @(posedge clk);
    cfg_idx  <= beds_pkg::CFG_RADIUS;
    cfg_data <= beds_pkg::CFG_DATA_W'(rad);
    @(posedge clk);
    cfg_idx  <= beds_pkg::CFG_WIDTH;
    cfg_data <= beds_pkg::CFG_DATA_W'(wd);
    @(posedge clk);
    cfg_idx  <= beds_pkg::CFG_HEIGHT;
    cfg_data <= beds_pkg::CFG_DATA_W'(ht);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_mode   = m;
    cfg_radius = rad;
    cfg_width  = wd;
    cfg_height = ht;
  endtask

  task automatic pad_to_frame();
    while (pos_row != 0 || pos_col != 0)
      send_pixel(logic'($urandom_range(1)), 1'b0, '0, '0);
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin : result_sink
    px_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d", out_row, out_col));
      end else begin
        want = pending.pop_front();
        if (out_row !== want.row)
          report($sformatf("row got %0d want %0d", out_row, want.row));
        if (out_col !== want.col)
          report($sformatf("col got %0d want %0d", out_col, want.col));
        if (pixel_out !== want.px)
          report($sformatf("pixel at %0d,%0d got %b want %b",
                           want.row, want.col, pixel_out, want.px));
        if (last_flag !== want.last)
          report($sformatf("last flag at %0d,%0d got %b want %b",
                           want.row, want.col, last_flag, want.last));
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 20);
    end
  end

  initial begin : stimulus
    warmup_row_t     warmup [$];
    int unsigned     phase, n_items, dens, i, c;
    beds_pkg::mode_e m;
    logic [2:0]      rad;
    logic [11:0]     wd;
    logic [12:0]     ht;
    bit              mid_ok;

    // row 0 after reset is border, so every pixel comes straight back
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd0));
    warmup.push_back(pix_row(1'b0, 1'b1, 12'd0, 11'd1));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd2));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd3));
    // zero width and height read as one pixel
    warmup.push_back(cfg_row(beds_pkg::MODE_ERODE, 3'd1, 12'd0, 13'd0));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd0));
    warmup.push_back(pix_row(1'b0, 1'b1, 12'd0, 11'd0));
    // zero radius: interior everywhere, value unchanged in both modes
    warmup.push_back(cfg_row(beds_pkg::MODE_DILATE, 3'd0, 12'd0, 13'd0));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd0));
    warmup.push_back(pix_row(1'b0, 1'b1, 12'd0, 11'd0));
    warmup.push_back(cfg_row(beds_pkg::MODE_ERODE, 3'd0, 12'd0, 13'd0));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd0));
    warmup.push_back(pix_row(1'b0, 1'b1, 12'd0, 11'd0));
    // oversized geometry clamps to the maximum frame
    warmup.push_back(cfg_row(beds_pkg::MODE_DILATE, 3'd7, 12'hFFF, 13'h1FFF));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd0));
    warmup.push_back(pix_row(1'b0, 1'b1, 12'd0, 11'd1));
    // window wider than the frame, changed mid-frame: all border
    warmup.push_back(cfg_row(beds_pkg::MODE_DILATE, 3'd7, 12'd5, 13'd5));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd2));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd0, 11'd3));
    warmup.push_back(pix_row(1'b0, 1'b1, 12'd0, 11'd4));
    warmup.push_back(pix_row(1'b1, 1'b1, 12'd1, 11'd0));
    warmup.push_back(cfg_row(beds_pkg::MODE_ERODE, 3'd1, 12'd5, 13'd5));
    for (i = 0; i < 9; i++) warmup.push_back(pix_row(logic'(i != 8), 1'b0, '0, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (warmup[k]) begin
      if (warmup[k].is_cfg) begin
        settle_pending();
        write_regs(warmup[k].mode, warmup[k].radius, warmup[k].width, warmup[k].height);
      end else begin
        send_pixel(warmup[k].px, warmup[k].typed, warmup[k].row, warmup[k].col);
      end
    end

    phase = 0;
    while (sent_cnt < N_ITEMS) begin
      m = ($urandom_range(1) == 1) ? beds_pkg::MODE_DILATE : beds_pkg::MODE_ERODE;
      if (phase == 0) begin
        // long stretch with no idle cycles on either side
        rad = 3'd1; wd = 12'd20; ht = 13'd15;
        n_items = 300; dens = 50;
      end else if (phase == 1) begin
        // receiver holds off while pixels keep coming
        rad = 3'd2; wd = 12'd16; ht = 13'd12;
        n_items = 192; dens = 50;
      end else begin
        rad = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
        if (rad > 4) begin
          wd = 12'($urandom_range(12, 24));
          ht = 13'($urandom_range(12, 20));
        end else begin
          wd = 12'($urandom_range(1, 20));
          ht = 13'($urandom_range(1, 18));
        end
        if ($urandom_range(3) == 0) dens = 50;
        else if (m == beds_pkg::MODE_ERODE) dens = 80 + $urandom_range(19);
        else dens = $urandom_range(20);
        if ($urandom_range(3) != 0) n_items = wd * ht;
        else n_items = $urandom_range(1, wd * ht);
      end

      // a mid-frame change is only safe once every column in use has full history
      mid_ok = ($urandom_range(2) == 0);
      for (c = 0; c < wd; c++)
        if (col_fill[c] < HIST_W) mid_ok = 1'b0;
      if (!mid_ok) pad_to_frame();
      settle_pending();
      write_regs(m, rad, wd, ht);

      if (sent_cnt >= N_ITEMS) n_items = 0;
      else if (n_items > N_ITEMS - sent_cnt) n_items = N_ITEMS - sent_cnt;

      quiet = (phase == 0);
      if (phase == 1) hold_req = 1'b1;
      for (i = 0; i < n_items; i++)
        send_pixel(logic'($urandom_range(99) < dens), 1'b0, '0, '0);
      quiet = 1'b0;
      phase++;
    end

    settle_pending();
    if (err_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
